// ===== hdl/rc4_pkg.sv =====
// ----------------------------------------------------------------------------
// rc4_pkg : shared types and constants for the RC4 stream cipher engine
// Byte type, permutation geometry, input kind codes and register widths.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned PERM_DEPTH = 256;
  localparam int unsigned DISC_W     = 16;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [DISC_W-1:0] disc_t;

  // Input kind, carried on tuser
  localparam logic FUNC_KEY  = 1'b0;
  localparam logic FUNC_DATA = 1'b1;

endpackage

// ===== hdl/rc4_ram.sv =====
// ----------------------------------------------------------------------------
// rc4_ram : generic simple dual-port RAM
// One write port, one read port, read data registered.
// Contents are undefined after reset.
// ----------------------------------------------------------------------------
module rc4_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/rc4_stream_cipher_top.sv =====
// ----------------------------------------------------------------------------
// rc4_stream_cipher_top : RC4 engine, key schedule, drop and keystream XOR
// Data beat: RDJ, SWAP, FIN, result registered in FIN; next beat accepted in FIN
//   once the output is free; set by the read/swap/read sequence on the single-write
//   permutation RAM. Last key beat runs the schedule (KSI, KST/KSU per entry, KSF)
//   plus RDJ, SWAP, FIN per discarded byte. Reset: permutation reads as identity,
//   indices, key length and drop count cleared; key store undefined.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_top
  import rc4_pkg::*;
#(
  parameter int unsigned KEY_MAX = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: drop count
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // Input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  logic        s_axis_tuser_i,   // [0] func
  input  logic        s_axis_tlast_i,   // key_last
  // Output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // [7:0] out_byte, [15:8] keystream_byte
);

  localparam int unsigned KIDX_W = $clog2(KEY_MAX);
  localparam int unsigned LEN_W  = $clog2(KEY_MAX + 1);
  localparam int unsigned PADR_W = $clog2(PERM_DEPTH);

  // State codes
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RDJ  = 3'd1;
  localparam logic [2:0] ST_SWAP = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;
  localparam logic [2:0] ST_KSI  = 3'd4;
  localparam logic [2:0] ST_KST  = 3'd5;
  localparam logic [2:0] ST_KSU  = 3'd6;
  localparam logic [2:0] ST_KSF  = 3'd7;

  // Control and datapath registers
  logic [2:0]        state_q, state_d;
  byte_t             i_q, i_d;
  byte_t             j_q, j_d;
  byte_t             a_q, a_d;
  byte_t             b_q, b_d;
  byte_t             k_q, k_d;
  byte_t             byte_q, byte_d;
  logic [KIDX_W-1:0] kidx_q, kidx_d;
  logic [LEN_W-1:0]  key_len_q, key_len_d;
  logic              disc_q, disc_d;
  disc_t             disc_cnt_q, disc_cnt_d;
  disc_t             disc_count_q;
  logic              first_q, first_d;
  logic              out_valid_q, out_valid_d;
  byte_t             out_byte_q, out_byte_d;
  byte_t             ks_q, ks_d;

  // Permutation RAM ports and read-side tracking
  logic                   s_we;
  logic [PADR_W-1:0]      s_waddr;
  byte_t                  s_wdata;
  logic [PADR_W-1:0]      s_raddr;
  byte_t                  s_ram_rdata;
  byte_t                  s_rdata;
  logic [PERM_DEPTH-1:0]  vld_q;
  logic [PADR_W-1:0]      rd_addr_q;
  logic                   rd_vld_q;
  logic                   fwd_q;
  byte_t                  fwd_data_q;

  // Key RAM ports
  logic              k_we;
  logic [KIDX_W-1:0] k_waddr;
  byte_t             k_wdata;
  logic [KIDX_W-1:0] k_raddr;
  byte_t             k_rdata;

  // Helpers
  logic              in_acc;
  logic              out_free;
  byte_t             t_val;
  byte_t             ks_val;
  logic [LEN_W-1:0]  kidx_inc;
  logic [KIDX_W-1:0] kidx_nxt;

  rc4_ram #(.WIDTH(BYTE_W), .DEPTH(PERM_DEPTH)) u_perm_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_ram_rdata)
  );

  rc4_ram #(.WIDTH(BYTE_W), .DEPTH(KEY_MAX)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (k_we),
    .waddr_i (k_waddr),
    .wdata_i (k_wdata),
    .raddr_i (k_raddr),
    .rdata_o (k_rdata)
  );

  // Read data: same-cycle write forwarding, identity for unwritten entries
  assign s_rdata = fwd_q    ? fwd_data_q :
                   rd_vld_q ? s_ram_rdata : byte_t'(rd_addr_q);

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) ||
                           ((state_q == ST_FIN) && !disc_q && out_free);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // Schedule: entry n may still await the pending write of S[j]
  assign t_val = (!first_q && (i_q == j_q)) ? a_q : s_rdata;

  // Keystream byte: S[j'] and S[i'] are fresher than the RAM read
  assign ks_val = (k_q == j_q) ? a_q :
                  (k_q == i_q) ? b_q : s_rdata;

  // Key index wraps at the key length
  assign kidx_inc = LEN_W'(kidx_q) + LEN_W'(1);
  assign kidx_nxt = (kidx_inc == key_len_q) ? '0 : kidx_q + KIDX_W'(1);

  // Next state and RAM control
  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    a_d         = a_q;
    b_d         = b_q;
    k_d         = k_q;
    byte_d      = byte_q;
    kidx_d      = kidx_q;
    key_len_d   = key_len_q;
    disc_d      = disc_q;
    disc_cnt_d  = disc_cnt_q;
    first_d     = first_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_byte_d  = out_byte_q;
    ks_d        = ks_q;

    s_we    = 1'b0;
    s_waddr = j_q;
    s_wdata = a_q;
    s_raddr = k_q;
    k_we    = 1'b0;
    k_waddr = key_len_q[KIDX_W-1:0];
    k_wdata = s_axis_tdata_i;
    k_raddr = kidx_q;

    case (state_q)
      ST_IDLE, ST_FIN: begin
        if (state_q == ST_FIN) begin
          // Finish the swap, then deliver or drop the keystream byte
          s_we    = 1'b1;
          s_waddr = j_q;
          s_wdata = a_q;
          if (disc_q) begin
            if (disc_cnt_q == disc_t'(1)) begin
              disc_d  = 1'b0;
              state_d = ST_IDLE;
            end else begin
              disc_cnt_d = disc_cnt_q - disc_t'(1);
              i_d        = i_q + byte_t'(1);
              s_raddr    = i_q + byte_t'(1);
              state_d    = ST_RDJ;
            end
          end else if (out_free) begin
            out_valid_d = 1'b1;
            out_byte_d  = byte_q ^ ks_val;
            ks_d        = ks_val;
            state_d     = ST_IDLE;
          end
        end
        // New beat
        if (in_acc) begin
          if (s_axis_tuser_i == FUNC_DATA) begin
            i_d     = i_q + byte_t'(1);
            s_raddr = i_q + byte_t'(1);
            byte_d  = s_axis_tdata_i;
            state_d = ST_RDJ;
          end else begin
            if (key_len_q < LEN_W'(KEY_MAX)) begin
              k_we      = 1'b1;
              key_len_d = key_len_q + LEN_W'(1);
            end
            state_d = s_axis_tlast_i ? ST_KSI : ST_IDLE;
          end
        end
      end
      ST_RDJ: begin
        // a = S[i], fetch S[j + a]
        a_d     = s_rdata;
        j_d     = j_q + s_rdata;
        s_raddr = j_q + s_rdata;
        state_d = ST_SWAP;
      end
      ST_SWAP: begin
        // b = S[j], write S[i] = b, fetch S[a + b]
        s_we    = 1'b1;
        s_waddr = i_q;
        s_wdata = s_rdata;
        b_d     = s_rdata;
        k_d     = a_q + s_rdata;
        s_raddr = a_q + s_rdata;
        state_d = ST_FIN;
      end
      ST_KSI: begin
        // Schedule start: fetch S[0] and key[0]
        s_raddr = '0;
        k_raddr = '0;
        i_d     = '0;
        j_d     = '0;
        kidx_d  = '0;
        first_d = 1'b1;
        state_d = ST_KST;
      end
      ST_KST: begin
        // t = S[n]; retire previous S[j] write; fetch S[j + t + key]
        if (!first_q) begin
          s_we    = 1'b1;
          s_waddr = j_q;
          s_wdata = a_q;
        end
        a_d     = t_val;
        j_d     = j_q + t_val + k_rdata;
        s_raddr = j_q + t_val + k_rdata;
        first_d = 1'b0;
        state_d = ST_KSU;
      end
      ST_KSU: begin
        // S[n] = S[j]; fetch next entry and key byte
        s_we    = 1'b1;
        s_waddr = i_q;
        s_wdata = s_rdata;
        if (i_q == byte_t'(PERM_DEPTH - 1)) begin
          state_d = ST_KSF;
        end else begin
          i_d     = i_q + byte_t'(1);
          s_raddr = i_q + byte_t'(1);
          kidx_d  = kidx_nxt;
          k_raddr = kidx_nxt;
          state_d = ST_KST;
        end
      end
      ST_KSF: begin
        // Last S[j] write, clear indices and key length, start drop run if any
        s_we      = 1'b1;
        s_waddr   = j_q;
        s_wdata   = a_q;
        key_len_d = '0;
        i_d       = '0;
        j_d       = '0;
        if (disc_count_q != '0) begin
          disc_d     = 1'b1;
          disc_cnt_d = disc_count_q;
          i_d        = byte_t'(1);
          s_raddr    = PADR_W'(1);
          state_d    = ST_RDJ;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      i_q          <= '0;
      j_q          <= '0;
      key_len_q    <= '0;
      disc_q       <= 1'b0;
      disc_cnt_q   <= '0;
      disc_count_q <= '0;
      first_q      <= 1'b1;
      out_valid_q  <= 1'b0;
      vld_q        <= '0;
      fwd_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      key_len_q   <= key_len_d;
      disc_q      <= disc_d;
      disc_cnt_q  <= disc_cnt_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
      fwd_q       <= s_we && (s_waddr == s_raddr);
      if (s_we) begin
        vld_q[s_waddr] <= 1'b1;
      end
      if (cfg_we_i) begin
        disc_count_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    b_q        <= b_d;
    k_q        <= k_d;
    byte_q     <= byte_d;
    kidx_q     <= kidx_d;
    out_byte_q <= out_byte_d;
    ks_q       <= ks_d;
    rd_addr_q  <= s_raddr;
    rd_vld_q   <= vld_q[s_raddr];
    fwd_data_q <= s_wdata;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {ks_q, out_byte_q};

  // Assertions
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_len_q <= LEN_W'(KEY_MAX))
    else $error("key length beyond key store depth");

  a_sched_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_KSF) |-> (i_q == byte_t'(PERM_DEPTH - 1)))
    else $error("key schedule ended before the last entry");

  a_disc_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (disc_q && (state_q != ST_IDLE)) |-> (disc_cnt_q != '0))
    else $error("drop run active with zero count");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> ($past(state_q) == ST_FIN) && !$past(disc_q))
    else $error("result beat raised outside a data byte finish");

endmodule

// ===== dv/rc4_stream_cipher_top_tb.sv =====
// ----------------------------------------------------------------------------
// rc4_stream_cipher_top_tb : self-checking bench for the RC4 stream engine
// Loads keys and data bytes over the input stream with random gaps and output
// stalls. A local copy of the cipher state predicts every result beat, which
// is then checked field by field in order of arrival.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_top_tb;
  import rc4_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned KEY_LIMIT = 256;

  // Result beat layout, lowest bits first: out_byte, keystream_byte
  typedef struct packed {
    byte_t ks_byte;
    byte_t out_byte;
  } cipher_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;   // [7:0] in_byte
  logic        s_axis_tuser_i = 1'b0; // [0] func
  logic        s_axis_tlast_i = 1'b0; // key_last
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;        // [7:0] out_byte, [15:8] keystream_byte

  rc4_stream_cipher_top #(.KEY_MAX(KEY_LIMIT)) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Cipher state mirror
  byte_t       perm_q [PERM_DEPTH];
  byte_t       key_q  [PERM_DEPTH];
  int unsigned key_len;
  byte_t       idx_i;
  byte_t       idx_j;
  disc_t       drop_cnt;

  cipher_res_t cipher_q [$];
  int unsigned err_cnt;
  int unsigned beats_sent;
  int unsigned res_seen;
  longint unsigned cyc;
  longint unsigned sched_done_at;
  bit          gaps_on;
  bit          stalls_on;
  int unsigned stall_left;

  always @(posedge clk_i) cyc <= cyc + 1;

  // One RC4 generator step on the mirror
  function automatic byte_t next_keystream_byte();
    byte_t a, b, sum;
    idx_i = idx_i + 8'd1;
    a = perm_q[idx_i];
    idx_j = idx_j + a;
    b = perm_q[idx_j];
    perm_q[idx_i] = b;
    perm_q[idx_j] = a;
    sum = a + b;
    return perm_q[sum];
  endfunction

  // Key schedule, index clear and keystream drop
  function automatic void schedule_mirror();
    byte_t       j, t;
    int unsigned len;
    len = (key_len == 0) ? 1 : key_len;
    j = '0;
    for (int n = 0; n < PERM_DEPTH; n++) begin
      t = perm_q[n];
      j = j + t + key_q[n % len];
      perm_q[n] = perm_q[j];
      perm_q[j] = t;
    end
    idx_i = '0;
    idx_j = '0;
    for (int d = 0; d < drop_cnt; d++) void'(next_keystream_byte());
    key_len = 0;
  endfunction

  // Update mirror for one accepted input beat
  function automatic void predict_beat(logic func, byte_t data, logic last);
    byte_t       ks;
    cipher_res_t res;
    if (func == FUNC_DATA) begin
      ks = next_keystream_byte();
      res.out_byte = data ^ ks;
      res.ks_byte  = ks;
      cipher_q.push_back(res);
    end else begin
      // bytes past the key limit are dropped
      if (key_len < KEY_LIMIT) begin
        key_q[key_len] = data;
        key_len++;
      end
      if (last) begin
        schedule_mirror();
        // wait bound for the schedule plus the dropped bytes, with margin
        sched_done_at = cyc + 520 + 3 * longint'(drop_cnt) + 32;
      end
    end
  endfunction

  task automatic report_mismatch(input string what);
    err_cnt++;
    if (err_cnt <= 100) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Result checker
  always @(posedge clk_i) begin
    cipher_res_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      if (cipher_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with none pending (%04h)",
                                  res_seen, got));
      end else begin
        want = cipher_q.pop_front();
        if (got.out_byte !== want.out_byte)
          report_mismatch($sformatf("result %0d out_byte got %02h want %02h",
                                    res_seen, got.out_byte, want.out_byte));
        if (got.ks_byte !== want.ks_byte)
          report_mismatch($sformatf("result %0d keystream_byte got %02h want %02h",
                                    res_seen, got.ks_byte, want.ks_byte));
      end
      res_seen++;
    end
  end

  // Output back-pressure: random stall bursts
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready_i <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 14);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // Send one beat; tvalid stays high for a following beat
  task automatic send_beat(input logic func, input byte_t data, input logic last);
    int unsigned gap;
    gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= data;
    s_axis_tuser_i  <= func;
    s_axis_tlast_i  <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_beat(func, data, last);
    beats_sent++;
  endtask

  task automatic send_key(input int unsigned len);
    for (int unsigned k = 0; k < len; k++)
      send_beat(FUNC_KEY, byte_t'($urandom_range(0, 255)), k == len - 1);
  endtask

  task automatic send_data_run(input int unsigned len);
    for (int unsigned k = 0; k < len; k++)
      send_beat(FUNC_DATA, byte_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // Stop sending and wait for every pending result
  task automatic wait_results();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (cipher_q.size() != 0);
  endtask

  // Idle incl. any key schedule still running
  task automatic settle_block();
    wait_results();
    while (cyc < sched_done_at) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_drop(input disc_t value);
    settle_block();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    drop_cnt = value;
  endtask

  // Before any key the permutation is the identity
  task automatic test_identity_data();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    send_beat(FUNC_DATA, 8'h00, 1'b0);
    send_beat(FUNC_DATA, 8'hFF, 1'b1);
    send_beat(FUNC_DATA, 8'hA5, 1'b0);
    send_beat(FUNC_DATA, 8'h5A, 1'b1);
  endtask

  // One-byte keys at both extremes, data mixed into key loading
  task automatic test_short_keys();
    write_drop(16'h0000);
    send_beat(FUNC_KEY, 8'h00, 1'b1);
    send_beat(FUNC_DATA, 8'hFF, 1'b0);
    send_beat(FUNC_DATA, 8'h00, 1'b0);
    send_beat(FUNC_KEY, 8'hFF, 1'b1);
    send_beat(FUNC_DATA, 8'h00, 1'b1);
    send_beat(FUNC_KEY, 8'hFF, 1'b0);
    send_beat(FUNC_KEY, 8'hFF, 1'b0);
    send_beat(FUNC_KEY, 8'hFF, 1'b1);
    send_beat(FUNC_DATA, 8'h3C, 1'b0);
    // data between key bytes uses the old state
    send_beat(FUNC_KEY, 8'h12, 1'b0);
    send_beat(FUNC_DATA, 8'h81, 1'b0);
    send_beat(FUNC_KEY, 8'h34, 1'b1);
    send_beat(FUNC_DATA, 8'h7E, 1'b0);
  endtask

  // Key longer than the store: extra bytes ignored
  task automatic test_long_key();
    write_drop(16'h0001);
    send_key(KEY_LIMIT + 4);
    send_data_run(4);
  endtask

  // Largest drop count
  task automatic test_drop_extremes();
    write_drop(16'hFFFF);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    send_beat(FUNC_KEY, 8'h00, 1'b0);
    send_beat(FUNC_KEY, 8'hFF, 1'b0);
    send_beat(FUNC_KEY, 8'h80, 1'b1);
    send_data_run(4);
  endtask

  // Random key/data sequences with some noise
  task automatic test_random();
    int unsigned stop_at, quiet_at, seq, klen;
    stop_at  = beats_sent + 1150;
    quiet_at = beats_sent + 1000;
    seq = 0;
    write_drop(16'h0000);
    while (beats_sent < stop_at) begin
      if (beats_sent >= quiet_at) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end else begin
        gaps_on   = ($urandom_range(0, 3) != 0);
        stalls_on = ($urandom_range(0, 3) != 0);
      end
      if (seq % 6 == 5) begin
        case ($urandom_range(0, 3))
          0: write_drop(16'h0000);
          1: write_drop(disc_t'($urandom_range(1, 8)));
          2: write_drop(disc_t'($urandom_range(9, 64)));
          default: write_drop(disc_t'($urandom_range(65, 300)));
        endcase
      end else if (seq % 5 == 4) begin
        wait_results();
      end
      case ($urandom_range(0, 19))
        // data interleaved with key bytes
        0, 1, 2: begin
          klen = $urandom_range(1, 20);
          for (int unsigned k = 0; k < klen; k++) begin
            if ($urandom_range(0, 2) == 0) send_data_run(1);
            send_beat(FUNC_KEY, byte_t'($urandom_range(0, 255)), k == klen - 1);
          end
          send_data_run($urandom_range(1, 30));
        end
        // loose beats of any kind
        3, 4, 5: begin
          repeat ($urandom_range(1, 10))
            send_beat(1'($urandom_range(0, 1)), byte_t'($urandom_range(0, 255)),
                      $urandom_range(0, 7) == 0);
        end
        default: begin
          case ($urandom_range(0, 19))
            0:       klen = $urandom_range(256, 300);
            1, 2:    klen = $urandom_range(33, 255);
            default: klen = $urandom_range(1, 32);
          endcase
          send_key(klen);
          send_data_run($urandom_range(1, 60));
        end
      endcase
      seq++;
    end
  endtask

  initial begin
    err_cnt       = 0;
    beats_sent    = 0;
    res_seen      = 0;
    cyc           = 0;
    sched_done_at = 0;
    gaps_on       = 1'b0;
    stalls_on     = 1'b0;
    stall_left    = 0;
    for (int n = 0; n < PERM_DEPTH; n++) begin
      perm_q[n] = byte_t'(n);
      key_q[n]  = '0;
    end
    key_len  = 0;
    idx_i    = '0;
    idx_j    = '0;
    drop_cnt = '0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_identity_data();
    test_short_keys();
    test_long_key();
    test_drop_extremes();
    test_random();

    settle_block();
    repeat (16) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("[rc4_stream_cipher_top] OK");
    end else begin
      $display("[rc4_stream_cipher_top] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #50_000_000;
    $display("[rc4_stream_cipher_top] ERROR");
    $finish;
  end

endmodule

// ===== rc4_stream_cipher_top.f =====
hdl/rc4_pkg.sv
hdl/rc4_ram.sv
hdl/rc4_stream_cipher_top.sv
dv/rc4_stream_cipher_top_tb.sv
